@@ src/jkx_pkg.sv @@
package jkx_pkg;

  localparam int unsigned MAX_KEY_BYTES = 16;
  localparam int unsigned KEY_BITS      = 128;
  localparam int unsigned KEY_LEN_W     = 5;
  localparam int unsigned VALUE_W       = 64;

  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;

  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;

  typedef enum logic [4:0] {
    PH_SEARCH = 5'b00001,
    PH_BLANKS = 5'b00010,
    PH_QUOTED = 5'b00100,
    PH_BARE   = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_KEY_ABSENT = 3'd1,
    ST_NO_VALUE  = 3'd2,
    ST_UNCLOSED  = 3'd3,
    ST_BAD_HEX   = 3'd4
  } status_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    r.ok  = 1'b1;
    r.nib = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.nib = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.nib = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.nib = 4'(c - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09);
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return (c == 8'h2c) || (c == 8'h7d) || (c == 8'h5d) || (c == 8'h0a) || (c == 8'h0d);
  endfunction

  function automatic logic is_x(input logic [7:0] c);
    return (c == 8'h78) || (c == 8'h58);
  endfunction

endpackage

@@ src/json_key_hex_value_extractor_core.sv @@
// Scans a JSON document one byte per beat for the first "key": and returns the hex value
// that follows it. One input beat is taken every cycle unless held; the single result of a
// document appears in the output register in the cycle after the beat with tlast, and the
// input keeps flowing while that result waits unless a second result would overwrite it.
// The key search is a shift chain of MaxKeyBytes+3 cells, each holding one recent byte and
// comparing its next byte with its slot of quote, key, quote, colon, ANDed in the same cycle.
module json_key_hex_value_extractor_core #(
  parameter int unsigned MaxKeyBytes = jkx_pkg::MAX_KEY_BYTES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [63:0]                   cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // doc_byte
  input  logic                          s_axis_tlast,  // doc_last
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [71:0]                   m_axis_tdata   // status, parsed_value, zero pad
);
  import jkx_pkg::*;

  localparam int unsigned WinDepth = MaxKeyBytes + 3;

  logic [63:0]          key_low_q;
  logic [63:0]          key_high_q;
  logic [KEY_LEN_W-1:0] key_len_q;

  logic                 in_acc;
  logic                 shift_en;
  logic                 doc_clr;
  logic [7:0]           win_byte [WinDepth];
  logic [WinDepth-1:0]  win_valid;
  logic [WinDepth-1:0]  win_hit;
  logic                 key_hit;

  phase_e               phase_q, phase_d;
  logic [VALUE_W-1:0]   acc_q, acc_d;
  logic [1:0]           vcc_q, vcc_d;
  logic                 fcz_q, fcz_d;
  logic                 err_q, err_d;
  logic                 take;
  hex_t                 hex;
  status_e              status;
  logic [7:0]           c;

  logic                 out_valid_q;
  status_e              out_status_q;
  logic [VALUE_W-1:0]   out_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        REG_KEY_HIGH: key_high_q <= cfg_data_i;
        REG_KEY_LEN:  key_len_q  <= cfg_data_i[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready || !s_axis_tlast;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign c             = s_axis_tdata;
  assign shift_en      = in_acc && (phase_q == PH_SEARCH);
  assign doc_clr       = in_acc && s_axis_tlast;

  for (genvar g = 0; g < WinDepth; g++) begin : g_win
    logic [7:0] b_in;
    logic       v_in;
    if (g == 0) begin : g_head
      assign b_in = c;
      assign v_in = 1'b1;
    end else begin : g_body
      assign b_in = win_byte[g-1];
      assign v_in = win_valid[g-1];
    end
    jkx_cell #(.Idx(g)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .clr_i     (doc_clr),
      .shift_i   (shift_en),
      .byte_i    (b_in),
      .valid_i   (v_in),
      .key_i     ({key_high_q, key_low_q}),
      .key_len_i (key_len_q),
      .byte_o    (win_byte[g]),
      .valid_o   (win_valid[g]),
      .hit_o     (win_hit[g])
    );
  end

  assign key_hit = (&win_hit) && (key_len_q <= KEY_LEN_W'(MaxKeyBytes));

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    vcc_d   = vcc_q;
    fcz_d   = fcz_q;
    err_d   = err_q;
    take    = 1'b0;
    hex     = hex_decode(c);
    unique case (phase_q)
      PH_SEARCH: begin
        if (key_hit) begin
          phase_d = PH_BLANKS;
        end
      end
      PH_BLANKS: begin
        if (is_blank(c)) begin
          phase_d = PH_BLANKS;
        end else if (c == CHAR_QUOTE) begin
          phase_d = PH_QUOTED;
        end else if (is_term(c)) begin
          phase_d = PH_DONE;
        end else begin
          phase_d = PH_BARE;
          take    = 1'b1;
        end
      end
      PH_QUOTED: begin
        if (c == CHAR_QUOTE) begin
          phase_d = PH_DONE;
        end else begin
          take = 1'b1;
        end
      end
      PH_BARE: begin
        if (is_term(c)) begin
          phase_d = PH_DONE;
        end else begin
          take = 1'b1;
        end
      end
      PH_DONE: ;
      default: ;
    endcase
    if (take) begin
      if (vcc_q == 2'd1 && fcz_q && is_x(c)) begin
        vcc_d = 2'd2;
      end else begin
        if (vcc_q == 2'd0 && c == 8'h30) begin
          fcz_d = 1'b1;
        end
        if (vcc_q < 2'd2) begin
          vcc_d = vcc_q + 2'd1;
        end
        if (hex.ok) begin
          acc_d = {acc_q[VALUE_W-5:0], hex.nib};
        end else begin
          err_d = 1'b1;
        end
      end
    end
    priority if (phase_d == PH_SEARCH) begin
      status = ST_KEY_ABSENT;
    end else if (phase_d == PH_BLANKS) begin
      status = ST_NO_VALUE;
    end else if (phase_d == PH_QUOTED) begin
      status = ST_UNCLOSED;
    end else if (err_d) begin
      status = ST_BAD_HEX;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      acc_q   <= '0;
      vcc_q   <= '0;
      fcz_q   <= 1'b0;
      err_q   <= 1'b0;
    end else if (doc_clr) begin
      phase_q <= PH_SEARCH;
      acc_q   <= '0;
      vcc_q   <= '0;
      fcz_q   <= 1'b0;
      err_q   <= 1'b0;
    end else if (in_acc) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      vcc_q   <= vcc_d;
      fcz_q   <= fcz_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (doc_clr) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (doc_clr) begin
      out_status_q <= status;
      out_value_q  <= (status == ST_OK) ? acc_d : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_value_q, out_status_q};

endmodule

@@ src/jkx_cell.sv @@
module jkx_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clr_i,
  input  logic                          shift_i,
  input  logic [7:0]                    byte_i,
  input  logic                          valid_i,
  input  logic [jkx_pkg::KEY_BITS-1:0]  key_i,
  input  logic [jkx_pkg::KEY_LEN_W-1:0] key_len_i,
  output logic [7:0]                    byte_o,
  output logic                          valid_o,
  output logic                          hit_o
);
  import jkx_pkg::*;

  localparam logic [5:0] Pos = 6'(Idx);

  logic [7:0] byte_q;
  logic       valid_q;
  logic [5:0] len_ext;
  logic [5:0] key_pos;
  logic [7:0] exp_byte;
  logic       in_use;

  // compare the byte this cell takes on the next shift
  always_comb begin
    len_ext = {1'b0, key_len_i};
    key_pos = len_ext + 6'd1 - Pos;
    in_use  = Pos <= (len_ext + 6'd2);
    if (Idx == 0) begin
      exp_byte = CHAR_COLON;
    end else if (Idx == 1 || Pos == (len_ext + 6'd2)) begin
      exp_byte = CHAR_QUOTE;
    end else begin
      exp_byte = key_i[{key_pos[3:0], 3'b000} +: 8];
    end
    hit_o = !in_use || (valid_i && (byte_i == exp_byte));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clr_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

@@ src/jkx_checker.sv @@
module jkx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input open whenever the output slot is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // last beat gives a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
    else $error("missing result after last beat");

  // value only with status ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2:0] != 3'd0) |-> (m_axis_tdata[66:3] == 64'd0))
    else $error("value with error status");

  // status in range and pad zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] <= 3'd4) && (m_axis_tdata[71:67] == 5'd0))
    else $error("bad status code");

endmodule

bind json_key_hex_value_extractor_core jkx_checker u_jkx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
